// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the spline evaluator RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CRS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spline evaluator assertion failed");

// Next-cycle implication, checked out of reset.
`define CRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spline evaluator assertion failed");

`endif

// ----- hdl/crs_pkg.sv -----
// Package for the Catmull-Rom spline evaluator: widths, constants, types.
// No dependencies; used by every crs_* module and the top level.
`default_nettype none

package crs_pkg;

    localparam int NUM_STG = 7;
    localparam int PTS_DLY = 4;

    localparam int PT_W   = 32;
    localparam int POS_W  = 17;
    localparam int TEN_W  = 14;
    localparam int XX_W   = 2 * POS_W - 1;
    localparam int TX_W   = TEN_W + POS_W;
    localparam int W28_W  = 36;
    localparam int WGT_W  = W28_W - 12;
    localparam int PROD_W = PT_W + WGT_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int TOT_W  = PROD_W + 2;
    localparam int RND_W  = TOT_W - 16;

    localparam logic [POS_W-1:0] X_ONE       = POS_W'(65536);
    localparam logic [TEN_W-1:0] TEN_RESET   = TEN_W'(2048);
    localparam logic [XX_W-1:0]  XX_HALF     = XX_W'(32768);
    localparam logic signed [W28_W-1:0] W_ONE  = W28_W'(64'sd268435456);
    localparam logic signed [W28_W-1:0] W_HALF = W28_W'(64'sd2048);
    localparam logic signed [TOT_W-1:0] S_HALF = TOT_W'(64'sd32768);
    localparam logic signed [PT_W-1:0]  VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PT_W-1:0]  VAL_MIN = 32'sh8000_0000;

    typedef logic signed [PT_W-1:0]  coord_t;
    typedef logic signed [WGT_W-1:0] weight_t;

    typedef struct packed {
        logic [NUM_STG-1:0] en;
        logic [NUM_STG-1:0] vld;
    } ctrl_t;

    typedef struct packed {
        weight_t w0;
        weight_t w1;
        weight_t w2;
        weight_t w3;
    } weights_t;

    typedef struct packed {
        coord_t a;
        coord_t b;
        coord_t c;
        coord_t d;
    } points_t;

endpackage

`default_nettype wire

// ----- hdl/crs_ctrl.sv -----
// Pipeline control: per-stage valid bits and load enables.
// Depends on crs_pkg.
`default_nettype none

module crs_ctrl
    import crs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  out_ready,
    output ctrl_t      ctrl
);

    logic [NUM_STG-1:0] vld_reg;
    logic [NUM_STG-1:0] vld_next;
    logic [NUM_STG-1:0] en;

    // a stage loads when empty or when its content moves on
    always_comb
    begin
        en[NUM_STG-1] = !vld_reg[NUM_STG-1] || out_ready;
        for (int i = NUM_STG - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NUM_STG; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctrl.en  = en;
    assign ctrl.vld = vld_reg;

endmodule

`default_nettype wire

// ----- hdl/crs_weights.sv -----
// Stages 1-4: position powers x^2, x^3, tension products, cubic weights.
// Depends on crs_pkg; enables come from crs_ctrl.
`default_nettype none

module crs_weights
    import crs_pkg::*;
(
    input  wire logic              clk,
    input  wire ctrl_t             ctrl,
    input  wire logic [TEN_W-1:0]  tension,
    input  wire logic [POS_W-1:0]  position,
    output weights_t               weights
);

    // stage 1
    logic [POS_W-1:0] x1_reg, x1_next;
    logic [XX_W-1:0]  xx1_reg, xx1_next;
    // stage 2
    logic [XX_W-1:0]  xx_rnd;
    logic [POS_W-1:0] x2_2_reg, x2_next;
    logic [XX_W-1:0]  x2x_2_reg, x2x_next;
    logic [TX_W-1:0]  p2_reg, p2_next;
    logic [TX_W-1:0]  q2_reg, q2_next;
    // stage 3
    logic [XX_W-1:0]  x2x_rnd;
    logic [POS_W-1:0] x2_3_reg;
    logic [POS_W-1:0] x3_3_reg, x3_next;
    logic [TX_W-1:0]  p3_reg, q3_reg;
    logic [TX_W-1:0]  r3_reg, r3_next;
    // stage 4
    logic signed [W28_W-1:0] sp, sq, sr, sx2, sx3;
    logic signed [W28_W-1:0] w0_28, w1_28, w2_28, w3_28;
    logic signed [W28_W-1:0] w0_rnd, w1_rnd, w2_rnd, w3_rnd;
    weights_t                wgt_reg, wgt_next;

    always_comb
    begin
        x1_next  = (position > X_ONE) ? X_ONE : position;
        xx1_next = {{(XX_W-POS_W){1'b0}}, x1_next} * {{(XX_W-POS_W){1'b0}}, x1_next};

        xx_rnd   = xx1_reg + XX_HALF;
        x2_next  = xx_rnd[XX_W-1:16];
        x2x_next = {{(XX_W-POS_W){1'b0}}, x2_next} * {{(XX_W-POS_W){1'b0}}, x1_reg};
        p2_next  = {{(TX_W-TEN_W){1'b0}}, tension} * {{(TX_W-POS_W){1'b0}}, x1_reg};
        q2_next  = {{(TX_W-TEN_W){1'b0}}, tension} * {{(TX_W-POS_W){1'b0}}, x2_next};

        x2x_rnd  = x2x_2_reg + XX_HALF;
        x3_next  = x2x_rnd[XX_W-1:16];
        r3_next  = {{(TX_W-TEN_W){1'b0}}, tension} * {{(TX_W-POS_W){1'b0}}, x3_next};

        sp  = $signed({{(W28_W-TX_W){1'b0}}, p3_reg});
        sq  = $signed({{(W28_W-TX_W){1'b0}}, q3_reg});
        sr  = $signed({{(W28_W-TX_W){1'b0}}, r3_reg});
        sx2 = $signed({{(W28_W-POS_W){1'b0}}, x2_3_reg});
        sx3 = $signed({{(W28_W-POS_W){1'b0}}, x3_3_reg});

        // weights in Q.28; 3.0 and 2.0 in Q4.12 are shifts of x^2, x^3
        w0_28 = (sq <<< 1) - sp - sr;
        w1_28 = W_ONE - (sx2 <<< 13) - (sx2 <<< 12) + (sx3 <<< 13) + sq - sr;
        w2_28 = sp + (sx2 <<< 13) + (sx2 <<< 12) - (sq <<< 1) + sr - (sx3 <<< 13);
        w3_28 = sr - sq;

        w0_rnd = w0_28 + W_HALF;
        w1_rnd = w1_28 + W_HALF;
        w2_rnd = w2_28 + W_HALF;
        w3_rnd = w3_28 + W_HALF;

        wgt_next.w0 = w0_rnd[W28_W-1:12];
        wgt_next.w1 = w1_rnd[W28_W-1:12];
        wgt_next.w2 = w2_rnd[W28_W-1:12];
        wgt_next.w3 = w3_rnd[W28_W-1:12];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            x1_reg  <= x1_next;
            xx1_reg <= xx1_next;
        end
        if (ctrl.en[1])
        begin
            x2_2_reg  <= x2_next;
            x2x_2_reg <= x2x_next;
            p2_reg    <= p2_next;
            q2_reg    <= q2_next;
        end
        if (ctrl.en[2])
        begin
            x2_3_reg <= x2_2_reg;
            x3_3_reg <= x3_next;
            p3_reg   <= p2_reg;
            q3_reg   <= q2_reg;
            r3_reg   <= r3_next;
        end
        if (ctrl.en[3])
        begin
            wgt_reg <= wgt_next;
        end
    end

    assign weights = wgt_reg;

endmodule

`default_nettype wire

// ----- hdl/crs_blend.sv -----
// Stages 1-7 data path for the control values: delay line, weighted
// products, adder tree, rounding and saturation. Depends on crs_pkg.
`default_nettype none

module crs_blend
    import crs_pkg::*;
(
    input  wire logic      clk,
    input  wire ctrl_t     ctrl,
    input  wire points_t   points,
    input  wire weights_t  weights,
    output coord_t         value,
    output logic           saturated
);

    points_t pts_reg [PTS_DLY];

    logic signed [PROD_W-1:0] prod0_reg, prod1_reg, prod2_reg, prod3_reg;
    logic signed [PROD_W-1:0] prod0_next, prod1_next, prod2_next, prod3_next;
    logic signed [PAIR_W-1:0] sum01_reg, sum23_reg, sum01_next, sum23_next;
    logic signed [TOT_W-1:0]  total, total_rnd;
    logic signed [RND_W-1:0]  s_rnd;
    logic                     ovf;
    coord_t                   value_reg, value_next;
    logic                     sat_reg, sat_next;

    always_comb
    begin
        prod0_next = $signed(pts_reg[PTS_DLY-1].a) * $signed(weights.w0);
        prod1_next = $signed(pts_reg[PTS_DLY-1].b) * $signed(weights.w1);
        prod2_next = $signed(pts_reg[PTS_DLY-1].c) * $signed(weights.w2);
        prod3_next = $signed(pts_reg[PTS_DLY-1].d) * $signed(weights.w3);

        sum01_next = {prod0_reg[PROD_W-1], prod0_reg} + {prod1_reg[PROD_W-1], prod1_reg};
        sum23_next = {prod2_reg[PROD_W-1], prod2_reg} + {prod3_reg[PROD_W-1], prod3_reg};

        total     = {sum01_reg[PAIR_W-1], sum01_reg} + {sum23_reg[PAIR_W-1], sum23_reg};
        total_rnd = total + S_HALF;
        s_rnd     = total_rnd[TOT_W-1:16];

        // out of range when the bits above the sign of a 32-bit value disagree
        ovf = (s_rnd[RND_W-1:PT_W-1] != {(RND_W-PT_W+1){1'b0}})
           && (s_rnd[RND_W-1:PT_W-1] != {(RND_W-PT_W+1){1'b1}});
        sat_next = ovf;
        if (ovf)
        begin
            value_next = s_rnd[RND_W-1] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            value_next = s_rnd[PT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            pts_reg[0] <= points;
        end
        for (int i = 1; i < PTS_DLY; i++)
        begin
            if (ctrl.en[i])
            begin
                pts_reg[i] <= pts_reg[i-1];
            end
        end
        if (ctrl.en[4])
        begin
            prod0_reg <= prod0_next;
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
            prod3_reg <= prod3_next;
        end
        if (ctrl.en[5])
        begin
            sum01_reg <= sum01_next;
            sum23_reg <= sum23_next;
        end
        if (ctrl.en[6])
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ----- hdl/catmull_rom_spline_eval.sv -----
// Catmull-Rom spline evaluator with tension: top level.
// Depends on crs_pkg, crs_ctrl, crs_weights, crs_blend, assert_macros.svh.
//
// Usage:
//   Input beat: point_a..point_d (signed Q16.16) and position (Q1.16,
//   values above 1.0 clamp to 1.0) on in_valid/in_ready.
//   Output beat: value (signed Q16.16, clipped to range) and saturated
//   on out_valid/out_ready, one output beat per input beat, in order.
//   Config beat: cfg_data on cfg_valid/cfg_ready sets the tension
//   (unsigned Q2.12); cfg_ready is always high. Write it only while the
//   pipeline is empty.
//   Stages: the beat crosses 7 stages (three multiply stages and one
//   sum/round stage for the weights, one product stage, one adder
//   stage, one final add/round/saturate stage).
//   Throughput: one beat per cycle. When the receiver stalls, stages
//   behind the stall keep filling their empty slots; in_ready falls only
//   once every stage holds a beat.
//   Reset: pipeline empties, tension returns to 0.5 (2048).
`default_nettype none
`include "assert_macros.svh"

module catmull_rom_spline_eval
    import crs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [PT_W-1:0]   point_a,
    input  wire logic [PT_W-1:0]   point_b,
    input  wire logic [PT_W-1:0]   point_c,
    input  wire logic [PT_W-1:0]   point_d,
    input  wire logic [POS_W-1:0]  position,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [PT_W-1:0]        value,
    output logic                   saturated,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TEN_W-1:0]  cfg_data
);

    logic [TEN_W-1:0] tension_reg, tension_next;
    ctrl_t            ctrl;
    points_t          points;
    weights_t         weights;
    coord_t           value_int;

    always_comb
    begin
        tension_next = (cfg_valid && cfg_ready) ? cfg_data : tension_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= TEN_RESET;
        end
        else
        begin
            tension_reg <= tension_next;
        end
    end

    assign cfg_ready = 1'b1;

    assign points.a = $signed(point_a);
    assign points.b = $signed(point_b);
    assign points.c = $signed(point_c);
    assign points.d = $signed(point_d);

    crs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    crs_weights u_weights (
        .clk      (clk),
        .ctrl     (ctrl),
        .tension  (tension_reg),
        .position (position),
        .weights  (weights)
    );

    crs_blend u_blend (
        .clk       (clk),
        .ctrl      (ctrl),
        .points    (points),
        .weights   (weights),
        .value     (value_int),
        .saturated (saturated)
    );

    assign in_ready  = ctrl.en[0];
    assign out_valid = ctrl.vld[NUM_STG-1];
    assign value     = value_int;

    `CRS_ASSERT_IMPL(a_full_when_blocked, !in_ready, (ctrl.vld == {NUM_STG{1'b1}}) && !out_ready)
    `CRS_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, ctrl.vld[0])
    `CRS_ASSERT_IMPL(a_sat_at_limit, out_valid && saturated, (value == VAL_MAX) || (value == VAL_MIN))

endmodule

`default_nettype wire

// ----- bench/catmull_rom_spline_eval_test.sv -----
// Self-checking bench for catmull_rom_spline_eval: a directed table, then random beats
// under several tension settings, every output beat checked against the table or a local model.
// Depends on crs_pkg and the evaluator RTL.
module catmull_rom_spline_eval_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int PIPE_LATENCY = 7;
    localparam int MAX_GAP      = 8;
    localparam int LONG_HOLD    = 80;
    localparam int REPORT_LIMIT = 10;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int PHASE_BEATS  = 215;

    localparam longint UNIT_Q12 = 64'sd4096;
    localparam longint UNIT_Q28 = 64'sd268435456;

    typedef struct packed {
        coord_t value;
        logic   saturated;
    } sample_t;

    typedef struct packed {
        coord_t           a;
        coord_t           b;
        coord_t           c;
        coord_t           d;
        logic [POS_W-1:0] pos;
        logic             known;
        sample_t          result;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [PT_W-1:0]  point_a;
    logic [PT_W-1:0]  point_b;
    logic [PT_W-1:0]  point_c;
    logic [PT_W-1:0]  point_d;
    logic [POS_W-1:0] position;
    logic             out_valid;
    logic             out_ready;
    logic [PT_W-1:0]  value;
    logic             saturated;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [TEN_W-1:0] cfg_data;

    logic [TEN_W-1:0] tension_setting = TEN_RESET;
    sample_t          pending_samples[$];
    stim_row_t        directed_rows[$];
    int               mismatch_count = 0;
    int               beats_offered = 0;

    catmull_rom_spline_eval uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .point_a   (point_a),
        .point_b   (point_b),
        .point_c   (point_c),
        .point_d   (point_d),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint q28_to_q16(input longint w);
        return (w + 64'sd2048) >>> 12;
    endfunction

    function automatic sample_t spline_sample(input coord_t a, input coord_t b,
                                              input coord_t c, input coord_t d,
                                              input logic [POS_W-1:0] pos,
                                              input logic [TEN_W-1:0] ten);
        longint  x, sq, cube, t, w0, w1, w2, w3, acc, s;
        sample_t r;
        x    = (pos > X_ONE) ? longint'(X_ONE) : longint'(pos);
        sq   = (x * x + 64'sd32768) >>> 16;
        cube = (sq * x + 64'sd32768) >>> 16;
        t    = longint'(ten);
        w0 = q28_to_q16(-t * x + 2 * t * sq - t * cube);
        w1 = q28_to_q16(UNIT_Q28 + (t - 3 * UNIT_Q12) * sq + (2 * UNIT_Q12 - t) * cube);
        w2 = q28_to_q16(t * x + (3 * UNIT_Q12 - 2 * t) * sq + (t - 2 * UNIT_Q12) * cube);
        w3 = q28_to_q16(-t * sq + t * cube);
        acc = longint'(a) * w0 + longint'(b) * w1 + longint'(c) * w2 + longint'(d) * w3;
        s = (acc + 64'sd32768) >>> 16;
        r.saturated = 1'b1;
        if (s > longint'(VAL_MAX))
            r.value = VAL_MAX;
        else if (s < longint'(VAL_MIN))
            r.value = VAL_MIN;
        else
        begin
            r.value     = coord_t'(s);
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return coord_t'($urandom_range(0, 1048576)) - 32'sd524288;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_position();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return X_ONE;
            2:       return POS_W'($urandom_range(65537, 131071));
            default: return POS_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic add_row(input coord_t a, input coord_t b, input coord_t c,
                           input coord_t d, input logic [POS_W-1:0] pos,
                           input logic known, input coord_t ev, input logic es);
        stim_row_t row;
        row.a                = a;
        row.b                = b;
        row.c                = c;
        row.d                = d;
        row.pos              = pos;
        row.known            = known;
        row.result.value     = ev;
        row.result.saturated = es;
        directed_rows.push_back(row);
    endtask

    // Valid stays high across back-to-back beats; it is only lowered for a gap.
    task automatic offer_beat(input coord_t a, input coord_t b, input coord_t c,
                              input coord_t d, input logic [POS_W-1:0] pos,
                              input sample_t want);
        int gap;
        gap = (beats_offered % 64 < 16) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_a  <= a;
        point_b  <= b;
        point_c  <= c;
        point_d  <= d;
        position <= pos;
        do @(posedge clk); while (!in_ready);
        pending_samples.push_back(want);
        beats_offered++;
    endtask

    task automatic run_random(input int count);
        coord_t           a, b, c, d;
        logic [POS_W-1:0] pos;
        repeat (count)
        begin
            a   = rand_coord();
            b   = rand_coord();
            c   = rand_coord();
            d   = rand_coord();
            pos = rand_position();
            offer_beat(a, b, c, d, pos, spline_sample(a, b, c, d, pos, tension_setting));
        end
    endtask

    task automatic set_tension(input logic [TEN_W-1:0] t);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tension_setting = t;
    endtask

    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: output beat with none expected: value %h saturated %b",
                             $realtime, value, saturated);
                mismatch_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (value !== want.value || saturated !== want.saturated)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: value %h saturated %b, expected %h saturated %b",
                                 $realtime, value, saturated, want.value, want.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver; holds off for a long stretch twice so the pipeline backs up.
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken == 150 || taken == 800)
                gap = LONG_HOLD;
            else if (taken % 48 < 12)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial
    begin
        sample_t want;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        point_a   <= '0;
        point_b   <= '0;
        point_c   <= '0;
        point_d   <= '0;
        position  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // x = 0 gives point_b, x >= 1 gives point_c, for any tension
        add_row('0, '0, '0, '0, '0, 1'b1, '0, 1'b0);
        add_row(32'sh0001_0000, 32'sh1234_5678, -32'sh0002_8000, 32'sh7FFF_0000,
                '0, 1'b1, 32'sh1234_5678, 1'b0);
        add_row(32'sh0001_0000, 32'sh1234_5678, -32'sh0002_8000, 32'sh7FFF_0000,
                X_ONE, 1'b1, -32'sh0002_8000, 1'b0);
        add_row(32'sh0001_0000, 32'sh1234_5678, -32'sh0002_8000, 32'sh7FFF_0000,
                17'd65537, 1'b1, -32'sh0002_8000, 1'b0);
        add_row(32'sh0001_0000, 32'sh1234_5678, -32'sh0002_8000, 32'sh7FFF_0000,
                17'd131071, 1'b1, -32'sh0002_8000, 1'b0);
        add_row(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, '0, 1'b1, VAL_MAX, 1'b0);
        add_row(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, X_ONE, 1'b1, VAL_MIN, 1'b0);
        // overshoot at x = 0.5 with the reset tension clips both ways
        add_row(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, 17'd32768, 1'b1, VAL_MAX, 1'b1);
        add_row(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, 17'd32768, 1'b1, VAL_MIN, 1'b1);
        add_row(32'sh0001_0000, 32'sh1234_5678, -32'sh0002_8000, 32'sh7FFF_0000,
                17'd1, 1'b0, '0, 1'b0);
        add_row(32'sh0001_0000, 32'sh1234_5678, -32'sh0002_8000, 32'sh7FFF_0000,
                17'd65535, 1'b0, '0, 1'b0);
        add_row(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 17'd32768, 1'b0, '0, 1'b0);
        add_row(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 17'd16384, 1'b0, '0, 1'b0);
        add_row(32'sd0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                17'd21845, 1'b0, '0, 1'b0);
        add_row(32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001,
                17'd49152, 1'b0, '0, 1'b0);
        add_row(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 17'd43690, 1'b0, '0, 1'b0);

        foreach (directed_rows[i])
        begin
            want = directed_rows[i].known ? directed_rows[i].result
                 : spline_sample(directed_rows[i].a, directed_rows[i].b,
                                 directed_rows[i].c, directed_rows[i].d,
                                 directed_rows[i].pos, tension_setting);
            offer_beat(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                       directed_rows[i].d, directed_rows[i].pos, want);
        end

        run_random(PHASE_BEATS);
        set_tension('0);
        run_random(PHASE_BEATS);
        set_tension({TEN_W{1'b1}});
        run_random(PHASE_BEATS);
        set_tension(TEN_W'(4096));
        run_random(PHASE_BEATS);
        set_tension(TEN_W'($urandom_range(0, 16383)));
        run_random(PHASE_BEATS);
        set_tension(TEN_W'($urandom_range(0, 16383)));
        run_random(PHASE_BEATS);

        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 3) @(posedge clk);
        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("catmull_rom_spline_eval test passed");
        else
            $display("catmull_rom_spline_eval test failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("catmull_rom_spline_eval test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/crs_pkg.sv
hdl/crs_ctrl.sv
hdl/crs_weights.sv
hdl/crs_blend.sv
hdl/catmull_rom_spline_eval.sv
bench/catmull_rom_spline_eval_test.sv
